// ----- rtl/wsrt_pkg.sv -----
`timescale 1ns / 1ps

package wsrt_pkg;

  // Operation carried with each input item
  typedef enum logic [1:0] {
    FUNC_SUCCESS = 2'd0,
    FUNC_FAILURE = 2'd1,
    FUNC_QUERY   = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SHORT_LEN = 2'd0,
    CFG_LONG_LEN  = 2'd1,
    CFG_PRIOR     = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_COUNT,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

  localparam int POS_W     = 6;   // stored window position
  localparam int SLEN_W    = 6;   // short window length
  localparam int LLEN_W    = 7;   // long window length
  localparam int PRIOR_W   = 15;  // prior weight, 1/256 units
  localparam int CNT_W     = 7;   // popcount accumulators
  localparam int SCNT_W    = 6;   // short count as delivered
  localparam int LS_W      = 12;  // ll * sl
  localparam int ACC_W     = 13;  // lc*sl + sc*ll
  localparam int DEN_W     = 27;  // numerator / denominator of the ratio
  localparam int REM_W     = 28;  // divider partial remainder
  localparam int QUOT_W    = 18;  // floor(num * 2^17 / den)
  localparam int CHANCE_W  = 17;  // Q1.16 result, 65536 = 1.0
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 32;

endpackage

// ----- rtl/windowed_success_rate_tracker_unit.sv -----
`timescale 1ns / 1ps

// Windowed success-rate tracker. Each action keeps a short and a long circular
// window of outcome bits, all ones after reset. A transfer on the input stream
// (in_tuser = operation, in_tdata = action index) records a success or failure,
// clears the action's windows, or only queries them; one result transfer
// follows with the chance (L + S + 2P) / (2(P + 1)) in unsigned Q1.16 together
// with the window counts and the long window's full and empty flags. An item
// passes from its transfer through the window update, a count of the set bits
// a byte at a time, the one shared multiplier and the restoring divider to its
// result; an index beyond the action count goes from the update straight to
// the result. The block takes no new item until the current one has finished,
// but a finished result may wait in the output register while the next item
// is taken. Configuration writes are always accepted and must only be issued
// while the block is idle.

module windowed_success_rate_tracker_unit #(
  parameter int NUM_ACTIONS = 16,
  parameter int MAX_SHORT   = 63,
  parameter int MAX_LONG    = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] action_index, [7:4] zero
  input  logic [1:0]  in_tuser,   // [1:0] func
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [16:0] chance, [23:17] long_count,
                                  // [29:24] short_count, [30] long_full,
                                  // [31] long_empty
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);
  import wsrt_pkg::*;

  // Only the first sixteen actions can ever be addressed by a 4-bit index
  localparam int NA   = (NUM_ACTIONS < 16) ? NUM_ACTIONS : 16;
  localparam int AW   = (NA > 1) ? $clog2(NA) : 1;
  localparam int WMAX = (MAX_LONG > MAX_SHORT) ? MAX_LONG : MAX_SHORT;
  localparam int NCH  = (WMAX + 7) / 8;
  localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int SHW  = NCH * 8;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int k = 0; k < 8; k++) begin
      c = c + 4'(v[k]);
    end
    return c;
  endfunction

  // configuration registers
  logic [SLEN_W-1:0]  short_len_r;
  logic [LLEN_W-1:0]  long_len_r;
  logic [PRIOR_W-1:0] prior_r;

  // per-action window state
  logic [MAX_SHORT-1:0] sbits_r [NA];
  logic [MAX_LONG-1:0]  lbits_r [NA];
  logic [POS_W-1:0]     spos_r  [NA];
  logic [POS_W-1:0]     lpos_r  [NA];

  // item held while it is worked on
  state_t             state_r, state_nxt;
  func_t              func_r;
  logic [3:0]         idx_r;
  logic               oor_r;
  logic [SLEN_W-1:0]  sl_r;
  logic [LLEN_W-1:0]  ll_r;
  logic [PRIOR_W-1:0] pw_r;

  // counting and arithmetic
  logic [SHW-1:0]     ssh_r, lsh_r;
  logic [CNT_W-1:0]   sc_r, lc_r;
  logic [CHW-1:0]     chunk_r;
  logic [1:0]         mstep_r;
  logic [LS_W-1:0]    ls_r;
  logic [ACC_W-1:0]   acc_r;
  logic [DEN_W-1:0]   prodpw_r;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                  in_xfer;
  logic                  div_start;
  logic                  div_done;
  logic [QUOT_W-1:0]     quot;
  logic [DEN_W-1:0]      div_num, div_den;
  logic                  out_load;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_len_r <= SLEN_W'(5);
      long_len_r  <= LLEN_W'(25);
      prior_r     <= PRIOR_W'(64);
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SHORT_LEN: short_len_r <= cfg_data[SLEN_W-1:0];
        CFG_LONG_LEN:  long_len_r  <= cfg_data[LLEN_W-1:0];
        CFG_PRIOR:     prior_r     <= cfg_data;
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Item capture: clamp the lengths once so the rest of the item sees
  // stable effective values
  // ---------------------------------------------------------------------------
  logic [SLEN_W-1:0] sl_eff;
  logic [LLEN_W-1:0] ll_eff;

  always_comb begin
    if (short_len_r == '0) begin
      sl_eff = SLEN_W'(1);
    end else if (short_len_r > SLEN_W'(MAX_SHORT)) begin
      sl_eff = SLEN_W'(MAX_SHORT);
    end else begin
      sl_eff = short_len_r;
    end
    if (long_len_r == '0) begin
      ll_eff = LLEN_W'(1);
    end else if (long_len_r > LLEN_W'(MAX_LONG)) begin
      ll_eff = LLEN_W'(MAX_LONG);
    end else begin
      ll_eff = long_len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r <= func_t'(in_tuser);
      idx_r  <= in_tdata[3:0];
      oor_r  <= ({28'b0, in_tdata[3:0]} >= 32'(NUM_ACTIONS));
      sl_r   <= sl_eff;
      ll_r   <= ll_eff;
      pw_r   <= prior_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Window update: clear both windows, or advance both positions and set or clear the new bit
  // ---------------------------------------------------------------------------
  logic [AW-1:0]        ia;
  logic [POS_W:0]       sp_inc, lp_inc;
  logic [POS_W-1:0]     sp_new, lp_new;
  logic [MAX_SHORT-1:0] s_cur, s_new, s_mask;
  logic [MAX_LONG-1:0]  l_cur, l_new, l_mask;
  logic [POS_W-1:0]     sp_wr, lp_wr;
  logic                 win_we;

  assign ia    = idx_r[AW-1:0];
  assign s_cur = sbits_r[ia];
  assign l_cur = lbits_r[ia];

  always_comb begin
    sp_inc = {1'b0, spos_r[ia]} + 1'b1;
    lp_inc = {1'b0, lpos_r[ia]} + 1'b1;
    sp_new = (sp_inc >= (POS_W + 1)'(sl_r)) ? '0 : sp_inc[POS_W-1:0];
    lp_new = (lp_inc >= (POS_W + 1)'(ll_r)) ? '0 : lp_inc[POS_W-1:0];

    s_new  = s_cur;
    l_new  = l_cur;
    sp_wr  = spos_r[ia];
    lp_wr  = lpos_r[ia];
    win_we = 1'b0;
    case (func_r)
      FUNC_SUCCESS, FUNC_FAILURE: begin
        for (int j = 0; j < MAX_SHORT; j++) begin
          if (POS_W'(j) == sp_new) s_new[j] = (func_r == FUNC_SUCCESS);
        end
        for (int j = 0; j < MAX_LONG; j++) begin
          if (POS_W'(j) == lp_new) l_new[j] = (func_r == FUNC_SUCCESS);
        end
        sp_wr  = sp_new;
        lp_wr  = lp_new;
        win_we = 1'b1;
      end
      FUNC_CLEAR: begin
        s_new  = '0;
        l_new  = '0;
        sp_wr  = '0;
        lp_wr  = '0;
        win_we = 1'b1;
      end
      default: ;  // query: state holds
    endcase

    // count only the bits below the effective lengths
    for (int j = 0; j < MAX_SHORT; j++) begin
      s_mask[j] = (j < 32'(sl_r));
    end
    for (int j = 0; j < MAX_LONG; j++) begin
      l_mask[j] = (j < 32'(ll_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NA; i++) begin
        sbits_r[i] <= '1;
        lbits_r[i] <= '1;
        spos_r[i]  <= '0;
        lpos_r[i]  <= '0;
      end
    end else if (state_r == ST_UPDATE && !oor_r && win_we) begin
      sbits_r[ia] <= s_new;
      lbits_r[ia] <= l_new;
      spos_r[ia]  <= sp_wr;
      lpos_r[ia]  <= lp_wr;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier: ll*sl, lc*sl, sc*ll, then P * ll*sl
  // ---------------------------------------------------------------------------
  logic [PRIOR_W-1:0] mul_a;
  logic [LS_W-1:0]    mul_b;
  logic [DEN_W-1:0]   mul_p;

  always_comb begin
    case (mstep_r)
      2'd0: begin
        mul_a = PRIOR_W'(ll_r);
        mul_b = LS_W'(sl_r);
      end
      2'd1: begin
        mul_a = PRIOR_W'(lc_r);
        mul_b = LS_W'(sl_r);
      end
      2'd2: begin
        mul_a = PRIOR_W'(sc_r);
        mul_b = LS_W'(ll_r);
      end
      default: begin
        mul_a = pw_r;
        mul_b = ls_r;
      end
    endcase
    mul_p = DEN_W'(mul_a) * DEN_W'(mul_b);
  end

  // Halved form of the ratio: num = 128(lc*sl + sc*ll) + P*ll*sl,
  // den = (P + 256)*ll*sl, so num never exceeds den
  assign div_num = prodpw_r + (DEN_W'(acc_r) << 7);
  assign div_den = prodpw_r + (DEN_W'(ls_r) << 8);

  // ---------------------------------------------------------------------------
  // Datapath registers stepped by the sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      ST_UPDATE: begin
        ssh_r   <= SHW'(s_new & s_mask);
        lsh_r   <= SHW'(l_new & l_mask);
        sc_r    <= '0;
        lc_r    <= '0;
        chunk_r <= '0;
        mstep_r <= '0;
      end
      ST_COUNT: begin
        sc_r    <= sc_r + CNT_W'(pop8(ssh_r[7:0]));
        lc_r    <= lc_r + CNT_W'(pop8(lsh_r[7:0]));
        ssh_r   <= ssh_r >> 8;
        lsh_r   <= lsh_r >> 8;
        chunk_r <= chunk_r + 1'b1;
      end
      ST_MUL: begin
        mstep_r <= mstep_r + 1'b1;
        case (mstep_r)
          2'd0:    ls_r     <= mul_p[LS_W-1:0];
          2'd1:    acc_r    <= mul_p[ACC_W-1:0];
          2'd2:    acc_r    <= acc_r + mul_p[ACC_W-1:0];
          default: prodpw_r <= mul_p;
        endcase
      end
      default: ;
    endcase
  end

  wsrt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = oor_r ? ST_FINISH : ST_COUNT;
      end
      ST_COUNT: begin
        if (chunk_r == CHW'(NCH - 1)) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mstep_r == 2'd3) state_nxt = ST_DIV_START;
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result: round the 17-fraction-bit quotient to 16 bits, halves up
  // ---------------------------------------------------------------------------
  logic [QUOT_W-1:0]   quot_rnd;
  logic [CHANCE_W-1:0] chance;
  logic                full, empty;

  assign quot_rnd = quot + 1'b1;
  assign chance   = quot_rnd[QUOT_W-1:1];
  assign full     = (lc_r == CNT_W'(ll_r));
  assign empty    = (lc_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (oor_r) begin
        out_data_r <= '0;
      end else begin
        out_data_r <= {empty, full, sc_r[SCNT_W-1:0], lc_r, chance};
      end
    end
  end

endmodule

// ----- rtl/wsrt_div.sv -----
`timescale 1ns / 1ps

module wsrt_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [wsrt_pkg::DEN_W-1:0]  num,
  input  logic [wsrt_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [wsrt_pkg::QUOT_W-1:0] quot
);
  import wsrt_pkg::*;

  localparam int STEP_W = $clog2(QUOT_W);

  logic              busy_r;
  logic              first_r;
  logic [STEP_W-1:0] step_r;
  logic [REM_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [QUOT_W-1:0] quot_r;
  logic [REM_W-1:0]  trial;
  logic              ge;
  logic              last;

  // First step compares the dividend as it stands (num <= den), then shift
  assign trial = first_r ? rem_r : {rem_r[REM_W-2:0], 1'b0};
  assign ge    = (trial >= REM_W'(den_r));
  assign last  = (step_r == STEP_W'(QUOT_W - 1));
  assign done  = busy_r && last;
  assign quot  = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      first_r <= 1'b0;
      step_r  <= '0;
    end else if (start) begin
      busy_r  <= 1'b1;
      first_r <= 1'b1;
      step_r  <= '0;
    end else if (busy_r) begin
      first_r <= 1'b0;
      step_r  <= step_r + 1'b1;
      if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= REM_W'(num);
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? (trial - REM_W'(den_r)) : trial;
      quot_r <= {quot_r[QUOT_W-2:0], ge};
    end
  end

endmodule

// ----- rtl/wsrt_chk.sv -----
`timescale 1ns / 1ps

module wsrt_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item at a time: busy right after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in flight");

  // chance never exceeds 1.0
  a_chance_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |-> out_tdata[15:0] == 16'd0)
    else $error("chance above 1.0");

  // empty flag agrees with the long count and excludes full
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[31] |-> out_tdata[23:17] == 7'd0 && !out_tdata[30])
    else $error("long window flags disagree with count");

endmodule

bind windowed_success_rate_tracker_unit wsrt_chk u_wsrt_chk (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import wsrt_pkg::*;

  localparam int ACTIONS      = 16;
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int QUIET_LIMIT  = 3000;  // cycles with no transfer at all
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 175;

  // One result transfer, packed as out_tdata: long_empty is the top bit
  typedef struct packed {
    logic        long_empty;
    logic        long_full;
    logic [5:0]  short_count;
    logic [6:0]  long_count;
    logic [16:0] chance;
  } rate_result_t;

  // Tracks every action's windows and predicts the result returned per item
  class chance_predictor;
    logic [62:0]  short_bits [ACTIONS];
    logic [63:0]  long_bits  [ACTIONS];
    logic [5:0]   short_pos  [ACTIONS];
    logic [5:0]   long_pos   [ACTIONS];
    logic [5:0]   short_len;
    logic [6:0]   long_len;
    logic [14:0]  prior;
    rate_result_t expected_rates [$];
    int unsigned  mismatches;

    function new();
      for (int i = 0; i < ACTIONS; i++) begin
        short_bits[i] = '1;
        long_bits[i]  = '1;
        short_pos[i]  = '0;
        long_pos[i]   = '0;
      end
      short_len  = 6'd5;
      long_len   = 7'd25;
      prior      = 15'd64;
      mismatches = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [14:0] value);
      case (idx)
        CFG_SHORT_LEN: short_len = value[5:0];
        CFG_LONG_LEN:  long_len  = value[6:0];
        CFG_PRIOR:     prior     = value;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_rates.size();
    endfunction

    // Apply one accepted item to the windows and queue its expected result
    function void note_item(func_t op, logic [3:0] act);
      longint unsigned sl, ll, lc, sc, lp, sp, num, den, q;
      rate_result_t want;
      sl = (short_len == 0) ? 1 : short_len;
      ll = (long_len == 0) ? 1 : ((long_len > 64) ? 64 : long_len);
      if (op == FUNC_SUCCESS || op == FUNC_FAILURE) begin
        lp = long_pos[act] + 1;
        sp = short_pos[act] + 1;
        if (lp >= ll) lp = 0;
        if (sp >= sl) sp = 0;
        long_pos[act]  = lp[5:0];
        short_pos[act] = sp[5:0];
        long_bits[act][lp]  = (op == FUNC_SUCCESS);
        short_bits[act][sp] = (op == FUNC_SUCCESS);
      end else if (op == FUNC_CLEAR) begin
        long_bits[act]  = '0;
        short_bits[act] = '0;
        long_pos[act]   = '0;
        short_pos[act]  = '0;
      end
      lc = 0;
      sc = 0;
      for (int i = 0; i < 64; i++) begin
        if (i < ll && long_bits[act][i]) lc++;
        if (i < sl && i < 63 && short_bits[act][i]) sc++;
      end
      num = 256 * (lc * sl + sc * ll) + 2 * prior * ll * sl;
      den = 2 * (prior + 256) * ll * sl;
      q = (num * 65536 + den / 2) / den;
      if (q > 65536) q = 65536;
      want.chance      = q[16:0];
      want.long_count  = lc[6:0];
      want.short_count = sc[5:0];
      want.long_full   = (lc == ll);
      want.long_empty  = (lc == 0);
      expected_rates.push_back(want);
    endfunction

    function void check_result(logic [31:0] data);
      rate_result_t got, want;
      got = data;
      if (expected_rates.size() == 0) begin
        $error("result transfer with nothing expected: %h", data);
        mismatches++;
        return;
      end
      want = expected_rates.pop_front();
      if (got.chance != want.chance) begin
        $error("chance: expected %0d, actual %0d", want.chance, got.chance);
        mismatches++;
      end
      if (got.long_count != want.long_count) begin
        $error("long_count: expected %0d, actual %0d", want.long_count, got.long_count);
        mismatches++;
      end
      if (got.short_count != want.short_count) begin
        $error("short_count: expected %0d, actual %0d", want.short_count, got.short_count);
        mismatches++;
      end
      if (got.long_full != want.long_full) begin
        $error("long_full: expected %0d, actual %0d", want.long_full, got.long_full);
        mismatches++;
      end
      if (got.long_empty != want.long_empty) begin
        $error("long_empty: expected %0d, actual %0d", want.long_empty, got.long_empty);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;

  // Idling odds in percent, set per phase by the stimulus process
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // Hold-off requests from the stimulus side, served by the receiver
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  chance_predictor rates = new();

  windowed_success_rate_tracker_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: serve a requested hold-off first, otherwise stall at random
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (holds_asked != holds_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: check the result transfer before noting the input transfer of
  // the same edge, so a stray result never pairs with a fresh expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) rates.check_result(out_tdata);
      if (in_tvalid && in_tready) rates.note_item(func_t'(in_tuser), in_tdata[3:0]);
    end
  end

  // Watchdog: give up once no transfer of any kind has happened for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item, idling first at the phase's odds; hold it until taken.
  // Valid stays high on return so back-to-back items need not drop it between them.
  task automatic send_item(input func_t op, input logic [3:0] act);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0000, act};
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (rates.pending() != 0);
  endtask

  // Write all three registers while the block is idle
  task automatic set_windows(input logic [14:0] slen, input logic [14:0] llen,
                             input logic [14:0] pw);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SHORT_LEN;
    cfg_data  <= slen;
    do @(posedge clk); while (!cfg_ready);
    rates.set_register(CFG_SHORT_LEN, slen);
    cfg_index <= CFG_LONG_LEN;
    cfg_data  <= llen;
    do @(posedge clk); while (!cfg_ready);
    rates.set_register(CFG_LONG_LEN, llen);
    cfg_index <= CFG_PRIOR;
    cfg_data  <= pw;
    do @(posedge clk); while (!cfg_ready);
    rates.set_register(CFG_PRIOR, pw);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned sent, run, lean, pick;
    logic [3:0]  act;
    func_t       op;
    logic [14:0] slen, llen, pw;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset lengths, all windows full of ones
    send_item(FUNC_QUERY, 4'd0);
    send_item(FUNC_SUCCESS, 4'd1);
    send_item(FUNC_FAILURE, 4'd1);
    send_item(FUNC_CLEAR, 4'd2);
    send_item(FUNC_QUERY, 4'd2);
    send_item(FUNC_SUCCESS, 4'd2);
    send_item(FUNC_FAILURE, 4'd15);
    drain();

    // Largest lengths and top of the prior range
    set_windows(15'd63, 15'd64, 15'd25600);
    send_item(FUNC_FAILURE, 4'd3);
    send_item(FUNC_SUCCESS, 4'd3);
    send_item(FUNC_QUERY, 4'd3);
    drain();

    // Zero lengths clamp to one; no prior at all
    set_windows(15'd0, 15'd0, 15'd0);
    send_item(FUNC_SUCCESS, 4'd4);
    send_item(FUNC_FAILURE, 4'd4);
    send_item(FUNC_CLEAR, 4'd4);
    drain();

    // Long length above range, prior above range, shortest short window
    set_windows(15'd1, 15'd127, 15'd32767);
    send_item(FUNC_FAILURE, 4'd5);
    send_item(FUNC_QUERY, 4'd1);
    drain();

    // Short window not below the long one
    set_windows(15'd40, 15'd10, 15'd64);
    send_item(FUNC_SUCCESS, 4'd6);
    send_item(FUNC_FAILURE, 4'd6);
    drain();

    // Random phases: runs of outcomes on one action so windows fill and empty,
    // with queries, clears and outcomes against the run's lean as noise
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain();
      case (phase % 4)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 68; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 68; end
        default: begin send_idle_pct <= 15; recv_stall_pct <= 15; end
      endcase
      if ($urandom_range(0, 5) == 0) begin
        slen = 15'($urandom_range(0, 63));
        llen = 15'($urandom_range(0, 127));
      end else begin
        llen = 15'($urandom_range(2, 64));
        slen = 15'($urandom_range(1, llen - 1));
      end
      case ($urandom_range(0, 5))
        0:       pw = 15'd0;
        1:       pw = 15'd25600;
        2:       pw = 15'd32767;
        default: pw = 15'($urandom_range(0, 25600));
      endcase
      set_windows(slen, llen, pw);
      // Stall the receiver for a long stretch while items keep coming
      if (phase == 0) holds_asked <= holds_asked + 1;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        act  = 4'((phase % 2 == 0) ? $urandom_range(0, 3) : $urandom_range(0, 15));
        lean = $urandom_range(0, 2);
        run  = $urandom_range(1, 80);
        if ($urandom_range(0, 7) == 0) begin
          send_item(FUNC_CLEAR, act);
          sent++;
        end
        for (int k = 0; k < run && sent < PHASE_ITEMS; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 8)
            op = FUNC_QUERY;
          else if (pick < 14)
            op = (lean == 0) ? FUNC_FAILURE : FUNC_SUCCESS;
          else if (lean == 0)
            op = FUNC_SUCCESS;
          else if (lean == 1)
            op = FUNC_FAILURE;
          else
            op = func_t'($urandom_range(0, 1));
          send_item(op, act);
          sent++;
        end
      end
    end

    drain();
    // Allow for any stray result after the last expected one
    repeat (40) @(posedge clk);
    if (rates.mismatches == 0 && rates.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/wsrt_pkg.sv
rtl/wsrt_div.sv
rtl/windowed_success_rate_tracker_unit.sv
rtl/wsrt_chk.sv
sim/tb.sv
